FILE: hdl/qrs_pkg.sv
package qrs_pkg;

    // extra fraction bits carried through the square root
    localparam int GUARD_BITS = 16;
    localparam int ROOT_WIDTH = 40;

    typedef logic [1:0] root_kind_t;

    localparam root_kind_t KIND_TWO     = 2'd0;
    localparam root_kind_t KIND_DOUBLE  = 2'd1;
    localparam root_kind_t KIND_COMPLEX = 2'd2;
    localparam root_kind_t KIND_DEGEN   = 2'd3;

    // saturation limits of a root
    localparam logic [ROOT_WIDTH-1:0] ROOT_MAX     = {1'b0, {(ROOT_WIDTH-1){1'b1}}};
    localparam logic [ROOT_WIDTH-1:0] ROOT_MIN_MAG = {1'b1, {(ROOT_WIDTH-1){1'b0}}};

endpackage

FILE: hdl/quadratic_root_solver.sv
// Pipeline, from the register that takes a request to the register that holds its result:
// 3 front stages, one square-root stage per root bit, one rounding-add stage, one divider
// stage per quotient bit, one output.
// Throughput: one request per cycle; busy is tied low and done is a one-cycle strobe.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// The receiver cannot stall, so the pipeline advances every cycle.
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS  = 8,
    parameter int COEF_WIDTH = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COEF_WIDTH-1:0] coef_a,
    input  logic signed [COEF_WIDTH-1:0] coef_b,
    input  logic signed [COEF_WIDTH-1:0] coef_c,
    output logic                         done,
    output logic [1:0]                   root_kind,
    output logic signed [ROOT_WIDTH-1:0] root_plus,
    output logic signed [ROOT_WIDTH-1:0] root_minus
);

    localparam int CW      = COEF_WIDTH;
    localparam int P_W     = 2 * CW;               // product width
    localparam int D_W     = 2 * CW + 1;           // discriminant width
    localparam int SQ_W    = CW + GUARD_BITS + 1;  // square-root result bits
    localparam int X_W     = 2 * SQ_W;             // radicand width
    localparam int REM_W   = SQ_W + 2;             // square-root remainder
    localparam int NP_W    = CW + GUARD_BITS + 2;  // numerator before scaling
    localparam int N_W     = NP_W + FRAC_BITS + 2; // rounded dividend
    localparam int Q_W     = CW + FRAC_BITS + 2;   // quotient bits
    localparam int DEN_W   = CW + GUARD_BITS + 2;  // divisor width
    localparam int CMP_W   = Q_W + ROOT_WIDTH;
    localparam int LATENCY = SQ_W + Q_W + 5;

    typedef struct packed {
        root_kind_t       kind;
        logic             sa;
        logic             sb;
        logic [CW-1:0]    ma;
        logic [CW-1:0]    mb;
        logic [X_W-1:0]   x;
        logic [REM_W-1:0] rem;
        logic [SQ_W-1:0]  root;
    } sq_t;

    typedef struct packed {
        root_kind_t       kind;
        logic             neg_p;
        logic             neg_m;
        logic [CW-1:0]    ma;
        logic [DEN_W-1:0] rem_p;
        logic [DEN_W-1:0] rem_m;
        logic [Q_W-1:0]   nq_p;
        logic [Q_W-1:0]   nq_m;
    } dv_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   nq;
    } dstep_t;

    // one restoring division step: next dividend bit from the top of nq,
    // quotient bit shifted in at the bottom
    function automatic dstep_t div_step(input logic [DEN_W-1:0] rem,
                                        input logic [Q_W-1:0] nq,
                                        input logic [DEN_W-1:0] den);
        logic [DEN_W:0] r;
        logic           ge;
        dstep_t         res;
        r = {rem, nq[Q_W-1]};
        ge = (r >= {1'b0, den});
        res.rem = ge ? DEN_W'(r - {1'b0, den}) : r[DEN_W-1:0];
        res.nq = {nq[Q_W-2:0], ge};
        return res;
    endfunction

    assign busy = 1'b0;

    // ---------------- stage 1: sign / magnitude ----------------
    logic          s1_vld_reg;
    logic          s1_sa_reg, s1_sb_reg, s1_sc_reg;
    logic [CW-1:0] s1_ma_reg, s1_mb_reg, s1_mc_reg;
    logic          take;

    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sa_reg <= coef_a[CW-1];
        s1_sb_reg <= coef_b[CW-1];
        s1_sc_reg <= coef_c[CW-1];
        s1_ma_reg <= coef_a[CW-1] ? CW'(-coef_a) : CW'(coef_a);
        s1_mb_reg <= coef_b[CW-1] ? CW'(-coef_b) : CW'(coef_b);
        s1_mc_reg <= coef_c[CW-1] ? CW'(-coef_c) : CW'(coef_c);
    end

    // ---------------- stage 2: products ----------------
    logic           s2_vld_reg;
    logic           s2_sa_reg, s2_sb_reg, s2_sc_reg, s2_cz_reg;
    logic [CW-1:0]  s2_ma_reg, s2_mb_reg;
    logic [P_W-1:0] s2_b2_reg, s2_ac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_sa_reg <= s1_sa_reg;
        s2_sb_reg <= s1_sb_reg;
        s2_sc_reg <= s1_sc_reg;
        s2_cz_reg <= (s1_mc_reg == '0);
        s2_ma_reg <= s1_ma_reg;
        s2_mb_reg <= s1_mb_reg;
        s2_b2_reg <= P_W'(s1_mb_reg) * P_W'(s1_mb_reg);
        s2_ac_reg <= P_W'(s1_ma_reg) * P_W'(s1_mc_reg);
    end

    // ---------------- stage 3: discriminant and class ----------------
    sq_t  sq_reg [0:SQ_W];
    logic sq_vld_reg [0:SQ_W];

    logic [D_W-1:0] b2_ext, p4, d_sum, d_dif, d_sel;
    root_kind_t     kind_next;

    always_comb
    begin
        b2_ext = D_W'(s2_b2_reg);
        p4     = {s2_ac_reg[P_W-2:0], 2'b00};
        d_sum  = b2_ext + p4;
        d_dif  = b2_ext - p4;
        if (s2_cz_reg || (s2_sa_reg != s2_sc_reg))
        begin
            d_sel     = d_sum;
            kind_next = (d_sum == '0) ? KIND_DOUBLE : KIND_TWO;
        end
        else
        begin
            d_sel = d_dif;
            if (b2_ext < p4)
                kind_next = KIND_COMPLEX;
            else if (b2_ext == p4)
                kind_next = KIND_DOUBLE;
            else
                kind_next = KIND_TWO;
        end
        if (s2_ma_reg == '0)
            kind_next = KIND_DEGEN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else
        begin
            sq_vld_reg[0] <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0].kind <= kind_next;
        sq_reg[0].sa   <= s2_sa_reg;
        sq_reg[0].sb   <= s2_sb_reg;
        sq_reg[0].ma   <= s2_ma_reg;
        sq_reg[0].mb   <= s2_mb_reg;
        sq_reg[0].x    <= {1'b0, d_sel, {(2*GUARD_BITS){1'b0}}};
        sq_reg[0].rem  <= '0;
        sq_reg[0].root <= '0;
    end

    // ---------------- square root: one result bit per stage ----------------
    for (genvar k = 0; k < SQ_W; k++)
    begin : g_sqrt
        logic [REM_W-1:0] r, trial;
        logic             ge;
        sq_t              sq_next;

        always_comb
        begin
            sq_next = sq_reg[k];
            r       = {sq_reg[k].rem[REM_W-3:0], sq_reg[k].x[2*(SQ_W-1-k) +: 2]};
            trial   = {sq_reg[k].root, 2'b01};
            ge      = (r >= trial);
            sq_next.rem  = ge ? (r - trial) : r;
            sq_next.root = {sq_reg[k].root[SQ_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[k+1] <= sq_next;
        end
    end

    // ---------------- numerators and rounding offset ----------------
    dv_t  dv_reg [0:Q_W];
    logic dv_vld_reg [0:Q_W];

    logic [NP_W-1:0] t_val, s_val, np, nm;
    logic            sp, sm;
    logic [N_W-1:0]  n_p, n_m, half;
    sq_t             sq_last;

    always_comb
    begin
        sq_last = sq_reg[SQ_W];
        t_val   = NP_W'(sq_last.mb) << GUARD_BITS;
        s_val   = NP_W'(sq_last.root);
        // plus root: -b + s
        if (sq_last.sb)
        begin
            sp = 1'b0;
            np = t_val + s_val;
        end
        else if (t_val >= s_val)
        begin
            sp = 1'b1;
            np = t_val - s_val;
        end
        else
        begin
            sp = 1'b0;
            np = s_val - t_val;
        end
        // minus root: -b - s
        if (!sq_last.sb)
        begin
            sm = 1'b1;
            nm = t_val + s_val;
        end
        else if (t_val >= s_val)
        begin
            sm = 1'b0;
            nm = t_val - s_val;
        end
        else
        begin
            sm = 1'b1;
            nm = s_val - t_val;
        end
        half = N_W'(sq_last.ma) << (GUARD_BITS + 1);
        n_p  = (N_W'(np) << (FRAC_BITS + 1)) + half;
        n_m  = (N_W'(nm) << (FRAC_BITS + 1)) + half;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else
        begin
            dv_vld_reg[0] <= sq_vld_reg[SQ_W];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0].kind  <= sq_last.kind;
        dv_reg[0].neg_p <= (sp != sq_last.sa);
        dv_reg[0].neg_m <= (sm != sq_last.sa);
        dv_reg[0].ma    <= sq_last.ma;
        dv_reg[0].rem_p <= DEN_W'(n_p[N_W-1:Q_W]);
        dv_reg[0].rem_m <= DEN_W'(n_m[N_W-1:Q_W]);
        dv_reg[0].nq_p  <= n_p[Q_W-1:0];
        dv_reg[0].nq_m  <= n_m[Q_W-1:0];
    end

    // ---------------- dividers: one quotient bit per stage ----------------
    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        logic [DEN_W-1:0] den;
        dstep_t           st_p, st_m;
        dv_t              dv_next;

        always_comb
        begin
            den  = {dv_reg[k].ma, {(GUARD_BITS+2){1'b0}}};
            st_p = div_step(dv_reg[k].rem_p, dv_reg[k].nq_p, den);
            st_m = div_step(dv_reg[k].rem_m, dv_reg[k].nq_m, den);
            dv_next       = dv_reg[k];
            dv_next.rem_p = st_p.rem;
            dv_next.nq_p  = st_p.nq;
            dv_next.rem_m = st_m.rem;
            dv_next.nq_m  = st_m.nq;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[k+1] <= dv_next;
        end
    end

    // ---------------- sign, saturation, output ----------------
    logic                  done_reg;
    root_kind_t            kind_reg;
    logic [ROOT_WIDTH-1:0] plus_reg, minus_reg;
    logic [ROOT_WIDTH-1:0] plus_next, minus_next;
    dv_t                   dv_last;

    function automatic logic [ROOT_WIDTH-1:0] finish(input logic [Q_W-1:0] q,
                                                      input logic neg);
        logic [CMP_W-1:0]      q_ext;
        logic [ROOT_WIDTH-1:0] mag;
        q_ext = CMP_W'(q);
        if (!neg)
        begin
            return (q_ext > CMP_W'(ROOT_MAX)) ? ROOT_MAX : q_ext[ROOT_WIDTH-1:0];
        end
        mag = (q_ext > CMP_W'(ROOT_MIN_MAG)) ? ROOT_MIN_MAG : q_ext[ROOT_WIDTH-1:0];
        return ROOT_WIDTH'(-mag);
    endfunction

    always_comb
    begin
        dv_last = dv_reg[Q_W];
        if ((dv_last.kind == KIND_COMPLEX) || (dv_last.kind == KIND_DEGEN))
        begin
            plus_next  = '0;
            minus_next = '0;
        end
        else
        begin
            plus_next  = finish(dv_last.nq_p, dv_last.neg_p);
            minus_next = finish(dv_last.nq_m, dv_last.neg_m);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= dv_last.kind;
        plus_reg  <= plus_next;
        minus_reg <= minus_next;
    end

    assign done       = done_reg;
    assign root_kind  = kind_reg;
    assign root_plus  = plus_reg;
    assign root_minus = minus_reg;

    // ---------------- checks ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##LATENCY done)
        else $error("request did not complete at the fixed latency");

    a_no_roots_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((root_kind == KIND_COMPLEX) || (root_kind == KIND_DEGEN)))
            |-> ((root_plus == '0) && (root_minus == '0)))
        else $error("roots not cleared for complex or degenerate request");

    a_double_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (root_kind == KIND_DOUBLE)) |-> (root_plus == root_minus))
        else $error("double root halves differ");

endmodule
